[hdl/rbli_pkg.sv]
// shared constants, types and arithmetic helpers for the range-bearing landmark init core
// no dependencies; used by rbli_sincos and range_bearing_landmark_init_core
`default_nettype none

package rbli_pkg;

	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_VAR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RB_COV    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BEAR_VAR  = 2'd2;

	localparam logic signed [15:0] PI_Q12    = 16'sd12868;
	localparam logic signed [15:0] TWOPI_Q12 = 16'sd25736;

	localparam logic [31:0] PI_Q30      = 32'd3373259426;
	localparam logic [31:0] HALFPI_Q30  = 32'd1686629713;
	localparam logic [30:0] QUARTPI_Q30 = 31'd843314856;
	localparam logic [30:0] ONE_Q30     = 31'd1073741824;

	localparam int unsigned COS_DIV [5] = '{90, 56, 30, 12, 2};
	localparam int unsigned SIN_DIV [4] = '{72, 42, 20, 6};

	// register stages inside the sine/cosine unit
	localparam int unsigned SC_LAT = 16;

	typedef struct packed {
		logic [63:0] ph;
		logic [47:0] pl;
		logic        neg;
	} rbb_part_t;

	// sign-magnitude product, truncated toward zero
	function automatic logic signed [63:0] smul(input logic signed [33:0] a,
			input logic signed [33:0] b, input int unsigned sh);
		logic [33:0] ma;
		logic [33:0] mb;
		logic [67:0] p;
		logic [67:0] q;
		ma = a[33] ? unsigned'(-a) : unsigned'(a);
		mb = b[33] ? unsigned'(-b) : unsigned'(b);
		p = 68'(ma) * 68'(mb);
		q = p >> sh;
		return (a[33] ^ b[33]) ? -signed'(q[63:0]) : signed'(q[63:0]);
	endfunction

	// first half of a 48 x 32 product, split in two partial products
	function automatic rbb_part_t split_rbb(input logic signed [48:0] v,
			input logic [31:0] rbb);
		logic [48:0] m;
		rbb_part_t r;
		m = v[48] ? unsigned'(-v) : unsigned'(v);
		r.ph = 64'(m[47:16]) * 64'(rbb);
		r.pl = 48'(m[15:0]) * 48'(rbb);
		r.neg = v[48];
		return r;
	endfunction

	function automatic logic signed [49:0] finish_rbb(input rbb_part_t p);
		logic [79:0] sum;
		logic signed [49:0] m;
		sum = {p.ph, 16'b0} + 80'(p.pl);
		m = signed'({2'b00, sum[79:32]});
		return p.neg ? -m : m;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -34'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
		logic signed [47:0] r;
		if (v > 52'sd140737488355327) begin
			r = 48'sh7fffffffffff;
		end else if (v < -52'sd140737488355328) begin
			r = 48'sh800000000000;
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/rbli_sincos.sv]
// pipelined sine and cosine of heading plus bearing, nested series in Q2.30
// depends on rbli_pkg; rbli_pkg::SC_LAT register stages, each advancing only while en is high
`default_nettype none

module rbli_sincos (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [14:0] heading,
	input  wire logic signed [14:0] bearing,
	output logic signed [31:0]      sine,
	output logic signed [31:0]      cosine
);

	typedef struct packed {
		logic [29:0] u;
		logic [29:0] u2;
		logic [30:0] tc;
		logic [30:0] ts;
		logic        neg;
		logic        second;
		logic        swap;
	} ser_t;

	logic signed [15:0] sum;
	logic signed [15:0] asum;
	logic signed [15:0] a_s1;
	logic [13:0]        amag;
	logic [31:0]        mshift;
	logic [31:0]        m_s2;
	logic               neg_s2;
	logic [30:0]        r_s3;
	logic               neg_s3;
	logic               second_s3;
	logic [29:0]        u_s4;
	logic               neg_s4;
	logic               second_s4;
	logic               swap_s4;
	logic [59:0]        usq;
	ser_t               ser_s [0:10];
	logic [30:0]        sv;
	logic [30:0]        cv;
	logic signed [31:0] svx;
	logic signed [31:0] cvx;
	logic signed [31:0] sine_s16;
	logic signed [31:0] cosine_s16;

	always_comb begin
		sum = 16'(heading) + 16'(bearing);
		asum = sum;
		if (sum > rbli_pkg::PI_Q12) begin
			asum = sum - rbli_pkg::TWOPI_Q12;
		end else if (sum < -rbli_pkg::PI_Q12) begin
			asum = sum + rbli_pkg::TWOPI_Q12;
		end
	end

	assign amag = a_s1[15] ? 14'(-a_s1) : a_s1[13:0];
	assign mshift = {amag, 18'b0};
	assign usq = 60'(u_s4) * 60'(u_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= asum;
			m_s2 <= (mshift > rbli_pkg::PI_Q30) ? rbli_pkg::PI_Q30 : mshift;
			neg_s2 <= a_s1[15];
			second_s3 <= m_s2 > rbli_pkg::HALFPI_Q30;
			r_s3 <= (m_s2 > rbli_pkg::HALFPI_Q30) ? 31'(rbli_pkg::PI_Q30 - m_s2) : m_s2[30:0];
			neg_s3 <= neg_s2;
			swap_s4 <= r_s3 > rbli_pkg::QUARTPI_Q30;
			u_s4 <= (r_s3 > rbli_pkg::QUARTPI_Q30) ?
				30'(rbli_pkg::HALFPI_Q30[30:0] - r_s3) : r_s3[29:0];
			neg_s4 <= neg_s3;
			second_s4 <= second_s3;
			ser_s[0] <= '{u: u_s4, u2: usq[59:30], tc: rbli_pkg::ONE_Q30,
				ts: rbli_pkg::ONE_Q30, neg: neg_s4, second: second_s4, swap: swap_s4};
		end
	end

	for (genvar i = 0; i < 5; i++) begin : g_step
		localparam int unsigned KC = rbli_pkg::COS_DIV[i];
		localparam int unsigned SC = 31 + $clog2(KC);
		localparam logic [32:0] MC = 33'(((64'd1 << SC) + 64'(KC) - 64'd1) / 64'(KC));

		logic [60:0] pc;
		logic [60:0] ps;
		logic [63:0] qc_full;
		logic [30:0] qc;

		assign pc = 61'(ser_s[2*i].u2) * 61'(ser_s[2*i].tc);
		assign ps = 61'((i < 4) ? ser_s[2*i].u2 : ser_s[2*i].u) * 61'(ser_s[2*i].ts);
		assign qc_full = 64'(ser_s[2*i+1].tc) * 64'(MC);
		assign qc = 31'(qc_full >> SC);

		always_ff @(posedge clk) begin
			if (en) begin
				ser_s[2*i+1] <= '{u: ser_s[2*i].u, u2: ser_s[2*i].u2, tc: pc[60:30],
					ts: ps[60:30], neg: ser_s[2*i].neg, second: ser_s[2*i].second,
					swap: ser_s[2*i].swap};
			end
		end

		if (i < 4) begin : g_sin
			localparam int unsigned KS = rbli_pkg::SIN_DIV[i];
			localparam int unsigned SS = 31 + $clog2(KS);
			localparam logic [32:0] MS = 33'(((64'd1 << SS) + 64'(KS) - 64'd1) / 64'(KS));

			logic [63:0] qs_full;
			logic [30:0] qs;

			assign qs_full = 64'(ser_s[2*i+1].ts) * 64'(MS);
			assign qs = 31'(qs_full >> SS);

			always_ff @(posedge clk) begin
				if (en) begin
					ser_s[2*i+2] <= '{u: ser_s[2*i+1].u, u2: ser_s[2*i+1].u2,
						tc: rbli_pkg::ONE_Q30 - qc, ts: rbli_pkg::ONE_Q30 - qs,
						neg: ser_s[2*i+1].neg, second: ser_s[2*i+1].second,
						swap: ser_s[2*i+1].swap};
				end
			end
		end else begin : g_sin_end
			always_ff @(posedge clk) begin
				if (en) begin
					ser_s[2*i+2] <= '{u: ser_s[2*i+1].u, u2: ser_s[2*i+1].u2,
						tc: rbli_pkg::ONE_Q30 - qc, ts: ser_s[2*i+1].ts,
						neg: ser_s[2*i+1].neg, second: ser_s[2*i+1].second,
						swap: ser_s[2*i+1].swap};
				end
			end
		end
	end

	assign sv = ser_s[10].swap ? ser_s[10].tc : ser_s[10].ts;
	assign cv = ser_s[10].swap ? ser_s[10].ts : ser_s[10].tc;
	assign svx = signed'({1'b0, sv});
	assign cvx = signed'({1'b0, cv});

	always_ff @(posedge clk) begin
		if (en) begin
			sine_s16 <= ser_s[10].neg ? -svx : svx;
			cosine_s16 <= ser_s[10].second ? -cvx : cvx;
		end
	end

	assign sine = sine_s16;
	assign cosine = cosine_s16;

endmodule

`default_nettype wire

[hdl/range_bearing_landmark_init_core.sv]
// top level: landmark position and covariance from one range-bearing observation
// depends on rbli_pkg and rbli_sincos
//
// channel   direction  handshake             payload
// cfg       in         cfg_we                cfg_index, cfg_wdata
// in        in         in_valid / in_stall   pose_x, pose_y, pose_heading, obs_range,
//                                            obs_bearing, obs_last
// out       out        out_valid / out_stall feat_x, feat_y, cov_xx, cov_xy, cov_yy,
//                                            result_last
//
// one transaction per cycle while the output is not stalled: the sine/cosine pipeline,
// then the product and covariance multiplier chain
// the whole pipeline holds while the output register is full and stalled
// reset clears valid bits and noise registers; no clearing pass

`default_nettype none

module range_bearing_landmark_init_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [rbli_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [31:0]                        cfg_wdata,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [31:0]                 pose_x,
	input  wire logic signed [31:0]                 pose_y,
	input  wire logic signed [14:0]                 pose_heading,
	input  wire logic [31:0]                        obs_range,
	input  wire logic signed [14:0]                 obs_bearing,
	input  wire logic                               obs_last,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [31:0]                      feat_x,
	output logic signed [31:0]                      feat_y,
	output logic signed [47:0]                      cov_xx,
	output logic signed [47:0]                      cov_xy,
	output logic signed [47:0]                      cov_yy,
	output logic                                    result_last
);

	localparam int unsigned L = rbli_pkg::SC_LAT;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic [31:0]        r;
		logic               last;
	} side_t;

	logic [31:0] rrr_q;
	logic [31:0] rrb_q;
	logic [31:0] rbb_q;

	logic        en;
	logic [L+5:1] vld_s;
	side_t       side_s [1:L];

	logic signed [31:0] sine;
	logic signed [31:0] cosine;

	logic signed [33:0] rrr34;
	logic signed [33:0] rrb34;

	logic signed [63:0] p_rc, p_rs;
	logic signed [32:0] rc_s17, rs_s17;
	logic signed [31:0] c_s17, s_s17, px_s17, py_s17;
	logic               last_s17;

	logic signed [63:0] p_cc, p_cs, p_ss, p_crs, p_src, p_crc, p_srs;
	logic signed [63:0] p_rsrs, p_rcrc, p_rsrc;
	logic signed [31:0] cc_s18, cs_s18, ss_s18;
	logic signed [32:0] crs_s18, src_s18, crc_s18, srs_s18;
	logic signed [48:0] rsrs_s18, rcrc_s18, rsrc_s18;
	logic signed [31:0] fx_s18, fy_s18;
	logic               last_s18;

	logic signed [63:0] p_axx, p_axy, p_ayy, p_bxx, p_byy;
	logic signed [33:0] d_s19;
	logic signed [32:0] axx_s19, axy_s19, ayy_s19;
	logic signed [48:0] bxx_s19, byy_s19;
	rbli_pkg::rbb_part_t cxx_s19, cxy_s19, cyy_s19;
	logic signed [31:0] fx_s19, fy_s19;
	logic               last_s19;

	logic signed [63:0] p_dr;
	logic signed [49:0] dr_s20, cxx_s20, cxy_s20, cyy_s20;
	logic signed [32:0] axx_s20, axy_s20, ayy_s20;
	logic signed [48:0] bxx_s20, byy_s20;
	logic signed [31:0] fx_s20, fy_s20;
	logic               last_s20;

	logic signed [31:0] fx_s21, fy_s21;
	logic signed [47:0] xx_s21, xy_s21, yy_s21;
	logic               last_s21;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rrr_q <= '0;
			rrb_q <= '0;
			rbb_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rbli_pkg::CFG_RANGE_VAR: rrr_q <= cfg_wdata;
				rbli_pkg::CFG_RB_COV:    rrb_q <= cfg_wdata;
				rbli_pkg::CFG_BEAR_VAR:  rbb_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign en = !(vld_s[L+5] && out_stall);
	assign in_stall = vld_s[L+5] && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[L+4:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= '{px: pose_x, py: pose_y, r: obs_range, last: obs_last};
			for (int k = 2; k <= L; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	rbli_sincos u_sincos (
		.clk     (clk),
		.en      (en),
		.heading (pose_heading),
		.bearing (obs_bearing),
		.sine    (sine),
		.cosine  (cosine)
	);

	assign rrr34 = signed'({2'b00, rrr_q});
	assign rrb34 = 34'(signed'(rrb_q));

	// range times cosine and sine
	assign p_rc = rbli_pkg::smul(signed'({2'b00, side_s[L].r}), 34'(cosine), 30);
	assign p_rs = rbli_pkg::smul(signed'({2'b00, side_s[L].r}), 34'(sine), 30);

	always_ff @(posedge clk) begin
		if (en) begin
			rc_s17 <= p_rc[32:0];
			rs_s17 <= p_rs[32:0];
			c_s17 <= cosine;
			s_s17 <= sine;
			px_s17 <= side_s[L].px;
			py_s17 <= side_s[L].py;
			last_s17 <= side_s[L].last;
		end
	end

	// jacobian cross products
	assign p_cc = rbli_pkg::smul(34'(c_s17), 34'(c_s17), 30);
	assign p_cs = rbli_pkg::smul(34'(c_s17), 34'(s_s17), 30);
	assign p_ss = rbli_pkg::smul(34'(s_s17), 34'(s_s17), 30);
	assign p_crs = rbli_pkg::smul(34'(c_s17), 34'(rs_s17), 30);
	assign p_src = rbli_pkg::smul(34'(s_s17), 34'(rc_s17), 30);
	assign p_crc = rbli_pkg::smul(34'(c_s17), 34'(rc_s17), 30);
	assign p_srs = rbli_pkg::smul(34'(s_s17), 34'(rs_s17), 30);
	assign p_rsrs = rbli_pkg::smul(34'(rs_s17), 34'(rs_s17), 16);
	assign p_rcrc = rbli_pkg::smul(34'(rc_s17), 34'(rc_s17), 16);
	assign p_rsrc = rbli_pkg::smul(34'(rs_s17), 34'(rc_s17), 16);

	always_ff @(posedge clk) begin
		if (en) begin
			cc_s18 <= p_cc[31:0];
			cs_s18 <= p_cs[31:0];
			ss_s18 <= p_ss[31:0];
			crs_s18 <= p_crs[32:0];
			src_s18 <= p_src[32:0];
			crc_s18 <= p_crc[32:0];
			srs_s18 <= p_srs[32:0];
			rsrs_s18 <= p_rsrs[48:0];
			rcrc_s18 <= p_rcrc[48:0];
			rsrc_s18 <= p_rsrc[48:0];
			fx_s18 <= rbli_pkg::sat32(34'(px_s17) + 34'(rc_s17));
			fy_s18 <= rbli_pkg::sat32(34'(py_s17) + 34'(rs_s17));
			last_s18 <= last_s17;
		end
	end

	assign p_axx = rbli_pkg::smul(34'(cc_s18), rrr34, 30);
	assign p_axy = rbli_pkg::smul(34'(cs_s18), rrr34, 30);
	assign p_ayy = rbli_pkg::smul(34'(ss_s18), rrr34, 30);
	assign p_bxx = rbli_pkg::smul(34'(crs_s18), rrb34, 16);
	assign p_byy = rbli_pkg::smul(34'(src_s18), rrb34, 16);

	always_ff @(posedge clk) begin
		if (en) begin
			d_s19 <= 34'(crc_s18) - 34'(srs_s18);
			axx_s19 <= p_axx[32:0];
			axy_s19 <= p_axy[32:0];
			ayy_s19 <= p_ayy[32:0];
			bxx_s19 <= p_bxx[48:0];
			byy_s19 <= p_byy[48:0];
			cxx_s19 <= rbli_pkg::split_rbb(rsrs_s18, rbb_q);
			cxy_s19 <= rbli_pkg::split_rbb(rsrc_s18, rbb_q);
			cyy_s19 <= rbli_pkg::split_rbb(rcrc_s18, rbb_q);
			fx_s19 <= fx_s18;
			fy_s19 <= fy_s18;
			last_s19 <= last_s18;
		end
	end

	assign p_dr = rbli_pkg::smul(d_s19, rrb34, 16);

	always_ff @(posedge clk) begin
		if (en) begin
			dr_s20 <= p_dr[49:0];
			cxx_s20 <= rbli_pkg::finish_rbb(cxx_s19);
			cxy_s20 <= rbli_pkg::finish_rbb(cxy_s19);
			cyy_s20 <= rbli_pkg::finish_rbb(cyy_s19);
			axx_s20 <= axx_s19;
			axy_s20 <= axy_s19;
			ayy_s20 <= ayy_s19;
			bxx_s20 <= bxx_s19;
			byy_s20 <= byy_s19;
			fx_s20 <= fx_s19;
			fy_s20 <= fy_s19;
			last_s20 <= last_s19;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s21 <= rbli_pkg::sat48(52'(axx_s20) - 52'(bxx_s20) - 52'(bxx_s20)
				+ 52'(cxx_s20));
			xy_s21 <= rbli_pkg::sat48(52'(axy_s20) + 52'(dr_s20) - 52'(cxy_s20));
			yy_s21 <= rbli_pkg::sat48(52'(ayy_s20) + 52'(byy_s20) + 52'(byy_s20)
				+ 52'(cyy_s20));
			fx_s21 <= fx_s20;
			fy_s21 <= fy_s20;
			last_s21 <= last_s20;
		end
	end

	assign out_valid = vld_s[L+5];
	assign feat_x = fx_s21;
	assign feat_y = fy_s21;
	assign cov_xx = xx_s21;
	assign cov_xy = xy_s21;
	assign cov_yy = yy_s21;
	assign result_last = last_s21;

endmodule

`default_nettype wire

[hdl/rbli_checker.sv]
// port-level checks for range_bearing_landmark_init_core, attached by bind
// depends on nothing but the top level's ports
`default_nettype none

module rbli_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [31:0] feat_x,
	input wire logic signed [47:0] cov_xx,
	input wire logic               result_last
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(feat_x) && $stable(cov_xx)
			&& $stable(result_last))
		else $error("stalled result changed");

	// input back pressure only from a full, stalled output register
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall without output back pressure");

	// reset empties the pipeline
	a_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

endmodule

bind range_bearing_landmark_init_core rbli_checker u_rbli_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.feat_x      (feat_x),
	.cov_xx      (cov_xx),
	.result_last (result_last)
);

`default_nettype wire
